### sv/dq_pkg.sv
// Shared types and codes for the bounded double-ended queue.
package dq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    typedef logic [1:0] kind_t;
    typedef logic [1:0] status_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam kind_t KIND_PUSH_FRONT = 2'd0;
    localparam kind_t KIND_PUSH_BACK  = 2'd1;
    localparam kind_t KIND_POP_FRONT  = 2'd2;
    localparam kind_t KIND_POP_BACK   = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

### sv/dq_if.sv
// Handshake channels for queue operations and their results.
interface dq_op_if;
    logic              valid;
    logic              ready;
    dq_pkg::kind_t     kind;
    dq_pkg::data_t     push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface dq_res_if;
    logic              valid;
    logic              ready;
    dq_pkg::data_t     pop_value;
    dq_pkg::status_t   status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);
endinterface

### sv/double_ended_queue_core.sv
// Bounded double-ended queue of signed 32-bit values held in a ring memory.
//
// Channels: op carries one operation per transaction (kind: push front, push
// back, pop front, pop back; push_value for pushes). result returns exactly
// one transaction per operation, in order: pop_value (zero unless a pop
// succeeded) and status (ok, empty on a pop of an empty queue, full on a
// push to a full queue). Failed operations leave the queue unchanged.
// After an operation is accepted, its result passes the synchronous memory
// read register and then the output register before it is valid.
// Throughput: one operation per cycle while result is not stalled; the front
// index and count update in the accept cycle, and the single memory port
// takes either the push write or the pop read of that operation.
// Reset: the queue is empty, front index zero, both stages empty; memory
// contents are not cleared and are only read once written.
// Stall: while result is not taken, the output register holds; the read
// stage behind it still accepts one more operation, after which op.ready
// drops until the output moves on.
module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    dq_op_if.sink    op,
    dq_res_if.source result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_DEPTH  = SUM_W'(DEPTH);

    dq_pkg::data_t   mem [DEPTH];
    dq_pkg::data_t   rdata_reg;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             s1_valid_reg;
    dq_pkg::status_t  s1_status_reg, s1_status_next;
    logic             s1_pop_reg, s1_pop_next;

    logic             out_valid_reg;
    dq_pkg::data_t    out_value_reg;
    dq_pkg::status_t  out_status_reg;

    logic             op_fire;
    logic             s1_move;
    logic             is_push;
    logic             mem_wr;
    logic             mem_rd;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] back_slot;
    logic [IDX_W-1:0] last_slot;
    logic [SUM_W-1:0] back_sum;
    logic [SUM_W-1:0] last_sum;
    logic [CNT_W-1:0] count_less;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || result.ready);
    assign op.ready = !s1_valid_reg || s1_move;
    assign op_fire  = op.valid && op.ready;
    assign is_push  = (op.kind == dq_pkg::KIND_PUSH_FRONT) ||
                      (op.kind == dq_pkg::KIND_PUSH_BACK);

    assign count_less = count_reg - CNT_W'(1);
    assign back_sum   = {1'b0, front_reg} + SUM_W'(count_reg);
    assign last_sum   = {1'b0, front_reg} + SUM_W'(count_less);
    assign back_slot  = (back_sum >= SUM_DEPTH) ? IDX_W'(back_sum - SUM_DEPTH)
                                                : IDX_W'(back_sum);
    assign last_slot  = (last_sum >= SUM_DEPTH) ? IDX_W'(last_sum - SUM_DEPTH)
                                                : IDX_W'(last_sum);

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        s1_status_next = dq_pkg::ST_OK;
        s1_pop_next    = 1'b0;
        mem_wr         = 1'b0;
        mem_rd         = 1'b0;
        slot           = front_reg;
        unique case (op.kind)
            dq_pkg::KIND_PUSH_FRONT:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    s1_status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    front_next = (front_reg == '0) ? IDX_LAST : front_reg - IDX_W'(1);
                    slot       = front_next;
                    count_next = count_reg + CNT_W'(1);
                    mem_wr     = op_fire;
                end
            end
            dq_pkg::KIND_PUSH_BACK:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    s1_status_next = dq_pkg::ST_FULL;
                end
                else
                begin
                    slot       = back_slot;
                    count_next = count_reg + CNT_W'(1);
                    mem_wr     = op_fire;
                end
            end
            dq_pkg::KIND_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    s1_status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    slot        = front_reg;
                    front_next  = (front_reg == IDX_LAST) ? '0 : front_reg + IDX_W'(1);
                    count_next  = count_less;
                    s1_pop_next = 1'b1;
                    mem_rd      = op_fire;
                end
            end
            dq_pkg::KIND_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    s1_status_next = dq_pkg::ST_EMPTY;
                end
                else
                begin
                    slot        = last_slot;
                    count_next  = count_less;
                    s1_pop_next = 1'b1;
                    mem_rd      = op_fire;
                end
            end
            default:
            begin
                s1_status_next = dq_pkg::ST_OK;
            end
        endcase
    end

    // Ring memory: write on push, registered read on pop.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[slot] <= op.push_value;
        end
        if (mem_rd)
        begin
            rdata_reg <= mem[slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_fire)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (op_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold payload of each stage until it advances.
    always_ff @(posedge clk)
    begin
        if (op_fire)
        begin
            s1_status_reg <= s1_status_next;
            s1_pop_reg    <= s1_pop_next;
        end
        if (s1_move)
        begin
            out_value_reg  <= s1_pop_reg ? rdata_reg : '0;
            out_status_reg <= s1_status_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.pop_value = out_value_reg;
    assign result.status    = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count exceeds depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= IDX_LAST)
        else $error("front index out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (op_fire && is_push && count_reg != FULL_COUNT)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not grow the queue");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (op_fire && !is_push && count_reg == '0)
        |=> (s1_status_reg == dq_pkg::ST_EMPTY && !s1_pop_reg && count_reg == '0))
        else $error("pop of empty queue not reported as empty");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |-> !op.ready)
        else $error("operation accepted with both stages occupied");

endmodule

### tb/double_ended_queue_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded double-ended queue core.
module double_ended_queue_core_tb;

    localparam int DEPTH          = dq_pkg::DEPTH_DEFAULT;
    localparam int FRONT_W        = $clog2(DEPTH);
    localparam int COUNT_W        = $clog2(DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        dq_pkg::data_t   pop_value;
        dq_pkg::status_t status;
    } deque_result_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    dq_op_if  op_ch ();
    dq_res_if res_ch ();

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch),
        .result(res_ch)
    );

    dq_pkg::data_t       ring_copy [DEPTH];
    logic [FRONT_W-1:0]  front_copy;
    logic [COUNT_W-1:0]  count_copy;
    deque_result_t       expected_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int idle_cycles    = 0;
    int kind_count [4];
    int status_count [3];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic deque_result_t apply_deque_op(dq_pkg::kind_t k, dq_pkg::data_t v);
        deque_result_t      r;
        logic [FRONT_W-1:0] slot;
        r.pop_value = '0;
        r.status    = dq_pkg::ST_OK;
        if (k == dq_pkg::KIND_PUSH_FRONT || k == dq_pkg::KIND_PUSH_BACK)
        begin
            if (count_copy >= DEPTH)
                r.status = dq_pkg::ST_FULL;
            else
            begin
                if (k == dq_pkg::KIND_PUSH_FRONT)
                begin
                    front_copy = FRONT_W'((int'(front_copy) + DEPTH - 1) % DEPTH);
                    slot = front_copy;
                end
                else
                    slot = FRONT_W'((int'(front_copy) + int'(count_copy)) % DEPTH);
                ring_copy[slot] = v;
                count_copy = count_copy + COUNT_W'(1);
            end
        end
        else
        begin
            if (count_copy == 0)
                r.status = dq_pkg::ST_EMPTY;
            else
            begin
                if (k == dq_pkg::KIND_POP_FRONT)
                begin
                    slot = front_copy;
                    front_copy = FRONT_W'((int'(front_copy) + 1) % DEPTH);
                end
                else
                    slot = FRONT_W'((int'(front_copy) + int'(count_copy) - 1) % DEPTH);
                r.pop_value = ring_copy[slot];
                count_copy = count_copy - COUNT_W'(1);
            end
        end
        return r;
    endfunction

    function automatic dq_pkg::data_t pick_value();
        dq_pkg::data_t v;
        case ($urandom_range(0, 7))
            0:       v = 32'sh7FFF_FFFF;
            1:       v = 32'sh8000_0000;
            2:       v = '0;
            3:       v = '1;
            default: v = dq_pkg::data_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_op(dq_pkg::kind_t k, dq_pkg::data_t v);
        deque_result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            op_ch.valid <= 1'b0;
            @(negedge clk);
        end
        op_ch.valid      <= 1'b1;
        op_ch.kind       <= k;
        op_ch.push_value <= v;
        @(posedge clk);
        while (op_ch.ready !== 1'b1)
            @(posedge clk);
        r = apply_deque_op(k, v);
        expected_results.push_back(r);
        kind_count[k]++;
        status_count[r.status]++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        op_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_pops();
        send_op(dq_pkg::KIND_POP_FRONT, 32'sh7FFF_FFFF);
        send_op(dq_pkg::KIND_POP_BACK, 32'sh8000_0000);
    endtask

    task automatic test_fill_to_full();
        send_op(dq_pkg::KIND_PUSH_BACK, 32'sh7FFF_FFFF);
        send_op(dq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000);
        send_op(dq_pkg::KIND_PUSH_BACK, '0);
        send_op(dq_pkg::KIND_PUSH_FRONT, '1);
        for (int i = 4; i < DEPTH; i++)
            send_op(i[0] ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_PUSH_BACK,
                    dq_pkg::data_t'($urandom));
        send_op(dq_pkg::KIND_PUSH_FRONT, dq_pkg::data_t'($urandom));
        send_op(dq_pkg::KIND_PUSH_BACK, dq_pkg::data_t'($urandom));
        send_op(dq_pkg::KIND_POP_FRONT, '1);
        send_op(dq_pkg::KIND_POP_BACK, '0);
        send_op(dq_pkg::KIND_POP_BACK, dq_pkg::data_t'($urandom));
        send_op(dq_pkg::KIND_POP_FRONT, dq_pkg::data_t'($urandom));
    endtask

    task automatic test_random_traffic(int items, int idle_pct, int stall_pct);
        traffic_mode_t mode;
        int            mode_left;
        int            roll;
        dq_pkg::kind_t k;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        mode_left      = 0;
        mode           = MODE_MIXED;
        for (int i = 0; i < items; i++)
        begin
            if (mode_left == 0)
            begin
                mode      = traffic_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            roll = $urandom_range(0, 99);
            case (mode)
                MODE_FILL:
                    k = (roll < 78) ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_POP_FRONT;
                MODE_DRAIN:
                    k = (roll < 78) ? dq_pkg::KIND_POP_FRONT : dq_pkg::KIND_PUSH_FRONT;
                default:
                    k = (roll < 50) ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_POP_FRONT;
            endcase
            if ($urandom_range(0, 1))
                k = (k == dq_pkg::KIND_PUSH_FRONT) ? dq_pkg::KIND_PUSH_BACK
                                                   : dq_pkg::KIND_POP_BACK;
            if (i % 113 == 57)
                hold_until_drained();
            send_op(k, pick_value());
        end
    endtask

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((op_ch.valid === 1'b1 && op_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results pending",
                     idle_cycles, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
        else if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result pop_value=%0d status=%0d",
                             $realtime, res_ch.pop_value, res_ch.status);
            end
            else
            begin
                deque_result_t want;
                want = expected_results.pop_front();
                if (res_ch.pop_value !== want.pop_value || res_ch.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: result %0d mismatch: pop_value exp %0d got %0d, ",
                                  "status exp %0d got %0d"},
                                 $realtime, results_seen, want.pop_value, res_ch.pop_value,
                                 want.status, res_ch.status);
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        op_ch.valid      = 1'b0;
        op_ch.kind       = dq_pkg::KIND_PUSH_FRONT;
        op_ch.push_value = '0;
        front_copy       = '0;
        count_copy       = '0;
        foreach (kind_count[i]) kind_count[i] = 0;
        foreach (status_count[i]) status_count[i] = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_empty_pops();
        test_fill_to_full();
        test_random_traffic(340, 0, 0);
        test_random_traffic(340, 52, 0);
        test_random_traffic(340, 0, 52);
        test_random_traffic(330, 19, 19);

        @(negedge clk);
        op_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        mismatches += expected_results.size();
        $display("Covered %0d push front, %0d push back, %0d pop front, %0d pop back;",
                 kind_count[dq_pkg::KIND_PUSH_FRONT], kind_count[dq_pkg::KIND_PUSH_BACK],
                 kind_count[dq_pkg::KIND_POP_FRONT], kind_count[dq_pkg::KIND_POP_BACK]);
        $display("%0d results: %0d ok, %0d empty pops, %0d full pushes; %0d mismatches",
                 results_seen, status_count[dq_pkg::ST_OK], status_count[dq_pkg::ST_EMPTY],
                 status_count[dq_pkg::ST_FULL], mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
